### design/ccff_pkg.sv
// Shared types and constants for the cluster centroid and footprint filter.
// Used by ccff_divider and cluster_centroid_footprint_filter_unit; no dependencies.
`default_nettype none

package ccff_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int SUM_WIDTH   = 32;
    localparam int CNT_WIDTH   = 16;
    localparam int QBIT_WIDTH  = $clog2(SUM_WIDTH);
    localparam int AREA_WIDTH  = 2 * COORD_WIDTH + 1;
    localparam int HGT_WIDTH   = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 64;

    localparam logic [CNT_WIDTH-1:0] MAX_CLUSTER_POINTS = 16'd65535;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic signed [HGT_WIDTH-1:0] HEIGHT_LIMIT_RST    = 16'sd20;
    localparam logic [AREA_WIDTH-1:0]       FOOTPRINT_LIMIT_RST = 33'd200000;

    typedef enum logic {
        REG_HEIGHT_LIMIT    = 1'b0,
        REG_FOOTPRINT_LIMIT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic                          last_point;
    } t_point;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] centroid_x;
        logic signed [OUT_WIDTH-1:0] centroid_y;
        logic signed [OUT_WIDTH-1:0] centroid_z;
    } t_centroid;

endpackage

`default_nettype wire

### design/ccff_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ccff_pkg for the sum and count widths.
`default_nettype none

module ccff_divider (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [ccff_pkg::SUM_WIDTH-1:0]     i_dividend,
    input  wire logic [ccff_pkg::CNT_WIDTH-1:0]     i_divisor,
    output logic                                    o_done,
    output logic [ccff_pkg::SUM_WIDTH-1:0]          o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [ccff_pkg::QBIT_WIDTH-1:0]    r_bit;
    logic [ccff_pkg::SUM_WIDTH-1:0]     r_dq;
    logic [ccff_pkg::CNT_WIDTH-1:0]     r_rem;
    logic [ccff_pkg::CNT_WIDTH-1:0]     r_dvs;

    logic [ccff_pkg::CNT_WIDTH:0]       w_rem_sh;
    logic                               w_ge;
    logic [ccff_pkg::CNT_WIDTH:0]       w_diff;
    logic [ccff_pkg::CNT_WIDTH-1:0]     n_rem;

    assign w_rem_sh = {r_rem, r_dq[ccff_pkg::SUM_WIDTH-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign n_rem    = w_ge ? w_diff[ccff_pkg::CNT_WIDTH-1:0]
                           : w_rem_sh[ccff_pkg::CNT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
            end else if (r_busy) begin
                r_bit <= r_bit + 1'b1;
                if (r_bit == ccff_pkg::QBIT_WIDTH'(ccff_pkg::SUM_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= {r_dq[ccff_pkg::SUM_WIDTH-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

`default_nettype wire

### design/cluster_centroid_footprint_filter_unit.sv
// Top level of the cluster centroid and footprint filter.
// Depends on ccff_pkg and ccff_divider.
//
// Usage: points of one cluster arrive on the input channel (i_in_valid / o_in_ready,
// payload i_in_point), one transaction per point, last_point set on the final one.
// Points that are not last are taken one per cycle; each updates the running sums,
// the point count (saturating at its limit) and the x and y minimum and maximum.
// After a last point the block stops taking points and runs one shared serial
// divider three times, once per axis, then squares both extents on one multiplier
// and sums the two squares into the footprint.
// If the count is not zero, centroid z is within the height limit and the
// footprint within the area limit, the centroid goes to the output register
// (o_out_valid / i_out_ready, payload o_out_centroid); otherwise nothing is sent.
// The accumulators clear and o_in_ready returns in the next cycle. A stalled receiver
// holds the result in the output register while the next cluster's points are taken;
// only a passing result of that next cluster waits for the register to drain.
// Reset clears the accumulators and the output valid flag, and sets both limits to
// their defaults. The APB port writes the height limit at 0x0 and the footprint
// limit at 0x8; pready is always high.
`default_nettype none

module cluster_centroid_footprint_filter_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire ccff_pkg::t_point                   i_in_point,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output ccff_pkg::t_centroid                     o_out_centroid,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ccff_pkg::APB_AW-1:0]        paddr,
    input  wire logic [ccff_pkg::APB_DW-1:0]        pwdata,
    output logic [ccff_pkg::APB_DW-1:0]             prdata,
    output logic                                    pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_DIV  = 6'b000100,
        S_SQX  = 6'b001000,
        S_SQY  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    localparam int CW = ccff_pkg::COORD_WIDTH;
    localparam int SW = ccff_pkg::SUM_WIDTH;

    t_state                             r_state;
    logic [1:0]                         r_axis;
    logic                               r_neg;

    logic signed [SW-1:0]               r_sum_x;
    logic signed [SW-1:0]               r_sum_y;
    logic signed [SW-1:0]               r_sum_z;
    logic [ccff_pkg::CNT_WIDTH-1:0]     r_count;
    logic signed [CW-1:0]               r_min_x;
    logic signed [CW-1:0]               r_max_x;
    logic signed [CW-1:0]               r_min_y;
    logic signed [CW-1:0]               r_max_y;

    logic signed [ccff_pkg::OUT_WIDTH-1:0] r_cx;
    logic signed [ccff_pkg::OUT_WIDTH-1:0] r_cy;
    logic signed [ccff_pkg::OUT_WIDTH-1:0] r_cz;
    logic [2*CW-1:0]                    r_prod;
    logic [2*CW-1:0]                    r_area;

    logic signed [ccff_pkg::HGT_WIDTH-1:0] r_height;
    logic [ccff_pkg::AREA_WIDTH-1:0]    r_fp_limit;

    logic                               r_out_valid;
    ccff_pkg::t_centroid                r_out;

    logic                               w_in_fire;
    logic                               w_upd;
    logic signed [SW-1:0]               w_sel_sum;
    logic [SW-1:0]                      w_mag;
    logic                               w_div_done;
    logic [SW-1:0]                      w_quot;
    logic [ccff_pkg::OUT_WIDTH-1:0]     w_q16;
    logic [ccff_pkg::OUT_WIDTH-1:0]     w_cval;
    logic [CW:0]                        w_dx;
    logic [CW:0]                        w_dy;
    logic [CW-1:0]                      w_ext;
    logic [2*CW-1:0]                    w_sq;
    logic [ccff_pkg::AREA_WIDTH-1:0]    w_area;
    logic                               w_pass;
    logic                               w_slot_free;
    logic                               w_cfg_wr;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_upd      = (r_count < ccff_pkg::MAX_CLUSTER_POINTS);

    always_comb begin
        case (r_axis)
            2'd0:    w_sel_sum = r_sum_x;
            2'd1:    w_sel_sum = r_sum_y;
            default: w_sel_sum = r_sum_z;
        endcase
    end

    assign w_mag = w_sel_sum[SW-1] ? SW'(-w_sel_sum) : SW'(w_sel_sum);

    ccff_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (w_mag),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_q16  = w_quot[ccff_pkg::OUT_WIDTH-1:0];
    assign w_cval = r_neg ? (~w_q16 + 1'b1) : w_q16;

    assign w_dx  = {r_max_x[CW-1], r_max_x} - {r_min_x[CW-1], r_min_x};
    assign w_dy  = {r_max_y[CW-1], r_max_y} - {r_min_y[CW-1], r_min_y};
    always_comb begin
        if (r_state == S_SQX) begin
            w_ext = w_dx[CW] ? '0 : w_dx[CW-1:0];
        end else begin
            w_ext = w_dy[CW] ? '0 : w_dy[CW-1:0];
        end
    end
    assign w_sq = w_ext * w_ext;

    assign w_area      = {1'b0, r_area} + {1'b0, r_prod};
    assign w_pass      = (r_cz <= r_height) && (w_area <= r_fp_limit) && (r_count != '0);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_count     <= '0;
            r_min_x     <= ccff_pkg::COORD_MAXV;
            r_max_x     <= ccff_pkg::COORD_MINV;
            r_min_y     <= ccff_pkg::COORD_MAXV;
            r_max_y     <= ccff_pkg::COORD_MINV;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (w_upd) begin
                            r_sum_x <= r_sum_x + {{(SW-CW){i_in_point.point_x[CW-1]}},
                                                  i_in_point.point_x};
                            r_sum_y <= r_sum_y + {{(SW-CW){i_in_point.point_y[CW-1]}},
                                                  i_in_point.point_y};
                            r_sum_z <= r_sum_z + {{(SW-CW){i_in_point.point_z[CW-1]}},
                                                  i_in_point.point_z};
                            r_count <= r_count + 1'b1;
                            if (i_in_point.point_x < r_min_x) r_min_x <= i_in_point.point_x;
                            if (i_in_point.point_x > r_max_x) r_max_x <= i_in_point.point_x;
                            if (i_in_point.point_y < r_min_y) r_min_y <= i_in_point.point_y;
                            if (i_in_point.point_y > r_max_y) r_max_y <= i_in_point.point_y;
                        end
                        if (i_in_point.last_point) begin
                            r_axis  <= 2'd0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_SQX;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!w_pass || w_slot_free) begin
                        if (w_pass) begin
                            r_out_valid <= 1'b1;
                        end
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_sum_z <= '0;
                        r_count <= '0;
                        r_min_x <= ccff_pkg::COORD_MAXV;
                        r_max_x <= ccff_pkg::COORD_MINV;
                        r_min_y <= ccff_pkg::COORD_MAXV;
                        r_max_y <= ccff_pkg::COORD_MINV;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_neg <= w_sel_sum[SW-1];
        end
        if (r_state == S_DIV && w_div_done) begin
            case (r_axis)
                2'd0:    r_cx <= w_cval;
                2'd1:    r_cy <= w_cval;
                default: r_cz <= w_cval;
            endcase
        end
        if (r_state == S_SQX) begin
            r_area <= w_sq;
        end
        if (r_state == S_SQY) begin
            r_prod <= w_sq;
        end
        if (r_state == S_EMIT && w_pass && w_slot_free) begin
            r_out.centroid_x <= r_cx;
            r_out.centroid_y <= r_cy;
            r_out.centroid_z <= r_cz;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_centroid = r_out;

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height   <= ccff_pkg::HEIGHT_LIMIT_RST;
            r_fp_limit <= ccff_pkg::FOOTPRINT_LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (ccff_pkg::t_reg_idx'(paddr[3]))
                ccff_pkg::REG_HEIGHT_LIMIT: begin
                    r_height <= pwdata[ccff_pkg::HGT_WIDTH-1:0];
                end
                ccff_pkg::REG_FOOTPRINT_LIMIT: begin
                    r_fp_limit <= pwdata[ccff_pkg::AREA_WIDTH-1:0];
                end
                default: begin
                    r_height <= r_height;
                end
            endcase
        end
    end

    always_comb begin
        case (ccff_pkg::t_reg_idx'(paddr[3]))
            ccff_pkg::REG_HEIGHT_LIMIT: begin
                prdata = {{(ccff_pkg::APB_DW-ccff_pkg::HGT_WIDTH)
                           {r_height[ccff_pkg::HGT_WIDTH-1]}}, r_height};
            end
            ccff_pkg::REG_FOOTPRINT_LIMIT: begin
                prdata = {{(ccff_pkg::APB_DW-ccff_pkg::AREA_WIDTH){1'b0}}, r_fp_limit};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign pready = 1'b1;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for cluster_centroid_footprint_filter_unit.
// Drives point clusters and APB limit writes, and checks each centroid against
// an in-line model of the filter. Depends on ccff_pkg and the RTL only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 140;
    localparam int HOLD_CYCLES  = 2500;
    localparam longint CYCLE_LIMIT = 1_000_000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    ccff_pkg::t_point              i_in_point = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    ccff_pkg::t_centroid           o_out_centroid;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ccff_pkg::APB_AW-1:0]   paddr = '0;
    logic [ccff_pkg::APB_DW-1:0]   pwdata = '0;
    logic [ccff_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    cluster_centroid_footprint_filter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_point     (i_in_point),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_centroid (o_out_centroid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    logic signed [ccff_pkg::HGT_WIDTH-1:0] height_lim;
    logic [ccff_pkg::AREA_WIDTH-1:0]       footprint_lim;
    longint                      sum_x, sum_y, sum_z;
    longint                      lo_x, hi_x, lo_y, hi_y;
    int                          n_points;

    ccff_pkg::t_point    point_q[$];
    ccff_pkg::t_centroid centroid_q[$];
    int        errors = 0;
    int        results_seen = 0;
    int        points_pushed = 0;
    int        points_taken = 0;
    longint    cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        seg_left = 0;
    int        seg_mode = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint sq_span(longint lo, longint hi);
        if (hi < lo) return 0;
        return (hi - lo) * (hi - lo);
    endfunction

    function automatic void clear_cluster();
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        n_points = 0;
        lo_x = ccff_pkg::COORD_MAXV;
        hi_x = ccff_pkg::COORD_MINV;
        lo_y = ccff_pkg::COORD_MAXV;
        hi_y = ccff_pkg::COORD_MINV;
    endfunction

    function automatic void accumulate_point(ccff_pkg::t_point p);
        longint px, py, pz, cx, cy, cz, area;
        ccff_pkg::t_centroid c;
        px = longint'(signed'(p.point_x));
        py = longint'(signed'(p.point_y));
        pz = longint'(signed'(p.point_z));
        if (n_points < int'(ccff_pkg::MAX_CLUSTER_POINTS)) begin
            sum_x += px;
            sum_y += py;
            sum_z += pz;
            n_points++;
            if (px < lo_x) lo_x = px;
            if (px > hi_x) hi_x = px;
            if (py < lo_y) lo_y = py;
            if (py > hi_y) hi_y = py;
        end
        if (p.last_point) begin
            if (n_points != 0) begin
                cx = sum_x / n_points;
                cy = sum_y / n_points;
                cz = sum_z / n_points;
                area = sq_span(lo_x, hi_x) + sq_span(lo_y, hi_y);
                if (cz <= longint'(height_lim) && area <= longint'(footprint_lim)) begin
                    c.centroid_x = 16'(cx);
                    c.centroid_y = 16'(cy);
                    c.centroid_z = 16'(cz);
                    centroid_q = {centroid_q, c};
                end
            end
            clear_cluster();
        end
    endfunction

    function automatic void compare_axis(string axis,
                                         logic signed [ccff_pkg::OUT_WIDTH-1:0] want,
                                         logic signed [ccff_pkg::OUT_WIDTH-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: centroid_%s expected %0d, got %0d", $time, axis, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        bit free;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                accumulate_point(i_in_point);
                points_taken++;
            end
            free = !i_in_valid || o_in_ready;
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (point_q.size() > 0) begin
                    i_in_point <= point_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        ccff_pkg::t_centroid want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (centroid_q.size() == 0) begin
                    errors++;
                    $display("%0t: centroid with no transaction expected, got %p",
                             $time, o_out_centroid);
                end else begin
                    want = centroid_q.pop_front();
                    compare_axis("x", want.centroid_x, o_out_centroid.centroid_x);
                    compare_axis("y", want.centroid_y, o_out_centroid.centroid_y);
                    compare_axis("z", want.centroid_z, o_out_centroid.centroid_z);
                end
            end
            if (!hold_done && results_seen >= 6 && o_out_valid && point_q.size() > 100) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 64);
                    seg_mode = $urandom_range(0, 2);
                end
                seg_left--;
                case (seg_mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_out_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    function automatic int near(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    task automatic push_point(int x, int y, int z, bit last);
        ccff_pkg::t_point p;
        p.point_x = 16'(x);
        p.point_y = 16'(y);
        p.point_z = 16'(z);
        p.last_point = last;
        point_q = {point_q, p};
        points_pushed++;
    endtask

    task automatic add_clusters(int n_items);
        int len, spread, cx, cy, cz, added;
        bit noisy;
        added = 0;
        while (added < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            noisy = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 2))
                0: spread = 50;
                1: spread = 600;
                default: spread = 20000;
            endcase
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 1))
                cz = int'(height_lim) + int'($urandom_range(0, 200)) - 100;
            else
                cz = int'($urandom_range(0, 65535)) - 32768;
            for (int i = 0; i < len; i++) begin
                if (noisy)
                    push_point(int'($urandom), int'($urandom), int'($urandom),
                               (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
                else
                    push_point(near(cx, spread), near(cy, spread), near(cz, spread / 4),
                               i == len - 1);
            end
            added += len;
        end
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (points_taken != points_pushed || centroid_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(ccff_pkg::t_reg_idx idx, logic [ccff_pkg::APB_DW-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == ccff_pkg::REG_HEIGHT_LIMIT)
            height_lim = value[ccff_pkg::HGT_WIDTH-1:0];
        else
            footprint_lim = value[ccff_pkg::AREA_WIDTH-1:0];
    endtask

    initial begin
        clear_cluster();
        height_lim = ccff_pkg::HEIGHT_LIMIT_RST;
        footprint_lim = ccff_pkg::FOOTPRINT_LIMIT_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_point(32767, 32767, -32768, 1);
        push_point(-32768, -32768, 32767, 1);
        push_point(-32768, 0, 0, 0);
        push_point(32767, 0, 0, 1);
        push_point(1, -1, -1, 0);
        push_point(2, -2, -2, 1);
        push_point(5, 5, 20, 1);
        push_point(5, 5, 21, 1);
        push_point(0, 0, 0, 0);
        push_point(400, 200, 0, 1);
        push_point(0, 0, 0, 0);
        push_point(400, 201, 0, 1);
        push_point(-7, 3, -5, 0);
        push_point(0, 0, 0, 0);
        push_point(-6, 4, -9, 1);
        settle();

        write_reg(ccff_pkg::REG_HEIGHT_LIMIT, 64'h7fff);
        write_reg(ccff_pkg::REG_FOOTPRINT_LIMIT, {31'd0, {33{1'b1}}});
        push_point(-32768, -32768, 0, 0);
        push_point(32767, 32767, 0, 1);
        push_point(-32768, 32767, 32767, 0);
        push_point(-32768, 32767, 32767, 1);
        settle();
        add_clusters(250);
        settle();

        write_reg(ccff_pkg::REG_HEIGHT_LIMIT, 64'hffff_ffff_ffff_8000);
        write_reg(ccff_pkg::REG_FOOTPRINT_LIMIT, 64'd0);
        push_point(-32768, 100, -32768, 1);
        push_point(-32768, 100, -32767, 1);
        push_point(9, 9, -32768, 0);
        push_point(9, 10, -32768, 1);
        add_clusters(60);
        settle();

        write_reg(ccff_pkg::REG_HEIGHT_LIMIT, 64'd0);
        write_reg(ccff_pkg::REG_FOOTPRINT_LIMIT, 64'd1_000_000);
        add_clusters(240);
        settle();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/ccff_pkg.sv
design/ccff_divider.sv
design/cluster_centroid_footprint_filter_unit.sv
tb/tb.sv
